// ===== rtl/core/gsa_pkg.sv =====
// ============================================================================
// gsa_pkg - shared types and constants of the generational slot allocator
// Opcodes, controller states and the result record passed between modules.
// ============================================================================
package gsa_pkg;

	// Fixed field widths of the command and response transactions.
	localparam int OPC_W = 3;
	localparam int IDX_W = 10;
	localparam int GEN_W = 32;

	// Command opcodes. Codes five to seven are unused and do nothing.
	typedef enum logic [OPC_W-1:0] {
		OP_CREATE  = 3'd0,
		OP_DESTROY = 3'd1,
		OP_RESTORE = 3'd2,
		OP_QUERY   = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_LINK,
		ST_RESP
	} state_t;

	// One response record.
	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
	} res_t;

endpackage

// ===== rtl/core/gsa_if.sv =====
// ============================================================================
// gsa_if - command and response channels of the slot allocator
// Valid/ready channels; a transaction completes when valid and ready are high.
// ============================================================================
interface gsa_cmd_if;
	import gsa_pkg::*;

	logic             valid;
	logic             ready;
	logic [OPC_W-1:0] opcode;
	logic [IDX_W-1:0] entity_index;
	logic [GEN_W-1:0] entity_generation;

	modport source (output valid, opcode, entity_index, entity_generation, input ready);
	modport sink (input valid, opcode, entity_index, entity_generation, output ready);
endinterface

interface gsa_rsp_if;
	import gsa_pkg::*;

	logic             valid;
	logic             ready;
	logic             ok;
	logic [IDX_W-1:0] result_index;
	logic [GEN_W-1:0] result_generation;

	modport source (output valid, ok, result_index, result_generation, input ready);
	modport sink (input valid, ok, result_index, result_generation, output ready);
endinterface

// ===== rtl/core/generational_slot_allocator_top.sv =====
// ============================================================================
// generational_slot_allocator_top - generational handle allocator
// Slot table in one RAM with an in-table free list, plus an output register.
// ============================================================================
//
//  Channel  Dir  Payload                                        Transaction
//  cmd      in   opcode, entity_index, entity_generation        valid & ready
//  rsp      out  ok, result_index, result_generation            valid & ready
//
// One command at a time: create, destroy, query and clear pass through the
// execute and response states. Restore walks the free list one entry per read,
// then writes the bypass into its predecessor and relinks the found slot; the
// single RAM read port sets this. Reset is asynchronous and the slot table
// needs no clearing pass. A stalled response waits in the output register
// while the next command is accepted and executed.

module generational_slot_allocator_top #(
	parameter int CAPACITY = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	gsa_cmd_if.sink   cmd,
	gsa_rsp_if.source rsp
);
	import gsa_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int EW = 1 + PW + GEN_W;

	res_t          res;
	logic          res_valid;
	logic          res_ready;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;
	res_t          out_q;
	logic          out_valid_q;

	// Slot table: alive flag, free list link and generation per slot.
	gsa_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_slot_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Controller.
	gsa_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// Output register loads when empty or when its transaction completes.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.ok                = out_q.ok;
	assign rsp.result_index      = out_q.index;
	assign rsp.result_generation = out_q.generation;

endmodule

// ===== rtl/core/gsa_ram.sv =====
// ============================================================================
// gsa_ram - generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ============================================================================
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/gsa_engine.sv =====
// ============================================================================
// gsa_engine - read-modify-write controller of the slot allocator
// Reads a slot entry, decides the operation, writes the entry back and walks
// the free list for restore. Holds one result until the output stage takes it.
// ============================================================================
module gsa_engine #(
	parameter int CAPACITY = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	gsa_cmd_if.sink                                 cmd,
	output gsa_pkg::res_t                           res,
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output logic                                    mem_we,
	output logic [$clog2(CAPACITY)-1:0]             mem_waddr,
	output logic [$clog2(CAPACITY+1)+gsa_pkg::GEN_W:0] mem_wdata,
	output logic                                    mem_re,
	output logic [$clog2(CAPACITY)-1:0]             mem_raddr,
	input  logic [$clog2(CAPACITY+1)+gsa_pkg::GEN_W:0] mem_rdata
);
	import gsa_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = (PW > IDX_W) ? PW : IDX_W;
	localparam logic [PW-1:0] LIST_END = PW'(CAPACITY);

	// One slot entry as stored in the memory.
	typedef struct packed {
		logic             alive;
		logic [PW-1:0]    next;
		logic [GEN_W-1:0] gen;
	} entry_t;

	state_t           state_q, state_d;
	logic [PW-1:0]    head_q, head_d;
	logic [PW-1:0]    used_q, used_d;
	logic [PW-1:0]    cur_q, cur_d;
	logic [PW-1:0]    steps_q, steps_d;
	logic [PW-1:0]    steps_inc;
	logic [OPC_W-1:0] op_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] gen_q;
	entry_t           ent_q;
	res_t             res_q, res_d;
	logic             ent_ld, res_ld;
	entry_t           rd, wr;
	logic [GEN_W-1:0] gen_inc;
	logic [CW-1:0]    idx_c, used_c, head_c, nxt_c;
	logic             alive_ok;

	assign rd        = entry_t'(mem_rdata);
	assign mem_wdata = wr;
	assign gen_inc   = rd.gen + GEN_W'(1);
	assign steps_inc = steps_q + PW'(1);
	assign idx_c     = CW'(idx_q);
	assign used_c    = CW'(used_q);
	assign head_c    = CW'(head_q);
	assign nxt_c     = CW'(rd.next);
	assign res       = res_q;

	// A handle is alive when its generation is nonzero, its slot is in use,
	// the slot is marked alive and the generations agree.
	assign alive_ok = (gen_q != '0) && (idx_c < used_c) && rd.alive && (rd.gen == gen_q);

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= LIST_END;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			used_q  <= used_d;
		end
	end

	// Payload registers: the command, the walk cursor and the result.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q  <= cmd.opcode;
			idx_q <= cmd.entity_index;
			gen_q <= cmd.entity_generation;
		end
		if (ent_ld) begin
			ent_q <= rd;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		cur_q   <= cur_d;
		steps_q <= steps_d;
	end

	// Next state, memory accesses and results. Every write lands before the
	// next read of the same entry is issued, so no forwarding is needed.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		used_d    = used_q;
		cur_d     = cur_q;
		steps_d   = steps_q;
		ent_ld    = 1'b0;
		res_ld    = 1'b0;
		res_d     = '0;
		mem_we    = 1'b0;
		mem_waddr = AW'(idx_q);
		wr        = '0;
		mem_re    = 1'b0;
		mem_raddr = AW'(idx_q);
		cmd.ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESP);

		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					mem_re = 1'b1;
					if (cmd.opcode == OP_CREATE) begin
						mem_raddr = AW'(head_q);
					end else begin
						mem_raddr = AW'(cmd.entity_index);
					end
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				state_d = ST_RESP;
				res_ld  = 1'b1;
				unique case (op_q)
					OP_CREATE: begin
						if (head_q < used_q) begin
							// Reuse the head of the free list.
							mem_we           = 1'b1;
							mem_waddr        = AW'(head_q);
							wr.alive         = 1'b1;
							wr.next          = LIST_END;
							wr.gen           = gen_inc;
							head_d           = rd.next;
							res_d.ok         = 1'b1;
							res_d.index      = IDX_W'(head_q);
							res_d.generation = gen_inc;
						end else if (used_q < LIST_END) begin
							// Append a fresh slot with generation one.
							mem_we           = 1'b1;
							mem_waddr        = AW'(used_q);
							wr.alive         = 1'b1;
							wr.next          = LIST_END;
							wr.gen           = GEN_W'(1);
							used_d           = used_q + PW'(1);
							res_d.ok         = 1'b1;
							res_d.index      = IDX_W'(used_q);
							res_d.generation = GEN_W'(1);
						end
					end
					OP_DESTROY: begin
						if (alive_ok) begin
							mem_we   = 1'b1;
							wr.alive = 1'b0;
							wr.next  = head_q;
							wr.gen   = rd.gen;
							head_d   = PW'(idx_q);
							res_d.ok = 1'b1;
						end
					end
					OP_RESTORE: begin
						if ((idx_c < used_c) && !rd.alive && (rd.gen == gen_q) &&
								(head_q < used_q)) begin
							if (head_c == idx_c) begin
								// The slot heads the free list.
								mem_we   = 1'b1;
								wr.alive = 1'b1;
								wr.next  = LIST_END;
								wr.gen   = rd.gen;
								head_d   = rd.next;
								res_d.ok = 1'b1;
							end else begin
								// Start the walk at the head of the list.
								ent_ld    = 1'b1;
								cur_d     = head_q;
								steps_d   = '0;
								mem_re    = 1'b1;
								mem_raddr = AW'(head_q);
								res_ld    = 1'b0;
								state_d   = ST_WALK;
							end
						end
					end
					OP_QUERY: begin
						res_d.ok = alive_ok;
					end
					OP_CLEAR: begin
						used_d   = '0;
						head_d   = LIST_END;
						res_d.ok = 1'b1;
					end
					default: begin
					end
				endcase
			end

			ST_WALK: begin
				if (nxt_c == idx_c) begin
					// Bypass the restored slot in its predecessor.
					mem_we    = 1'b1;
					mem_waddr = AW'(cur_q);
					wr.alive  = rd.alive;
					wr.next   = ent_q.next;
					wr.gen    = rd.gen;
					state_d   = ST_LINK;
				end else begin
					cur_d   = rd.next;
					steps_d = steps_inc;
					if ((steps_inc < LIST_END) && (rd.next < used_q)) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(rd.next);
					end else begin
						// The slot is not on the free list.
						res_ld  = 1'b1;
						state_d = ST_RESP;
					end
				end
			end

			ST_LINK: begin
				mem_we   = 1'b1;
				wr.alive = 1'b1;
				wr.next  = LIST_END;
				wr.gen   = ent_q.gen;
				res_d.ok = 1'b1;
				res_ld   = 1'b1;
				state_d  = ST_RESP;
			end

			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The read and write ports are never used in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("memory read and write issued in the same cycle");

	// The fill count never passes the table size.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= LIST_END)
		else $error("slot count beyond capacity");

	// The free list head is a used slot or the list end.
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < used_q) || (head_q == LIST_END))
		else $error("free list head points outside the used slots");

	// An accepted command is executed in the following cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q == ST_EXEC))
		else $error("accepted command did not enter execution");

	// The walk stays within its step bound.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (steps_q < LIST_END))
		else $error("free list walk exceeded its bound");

endmodule
